[hw/rtl/pcst_pkg.sv]
// Shared types and constants for the per-channel current statistics table.
// No dependencies; imported by the interfaces and every module.
package pcst_pkg;

	localparam int NUM_LAMPS_DEF = 16;

	localparam int IDX_W = 4;
	localparam int CUR_W = 16;
	localparam int CNT_W = 16;
	localparam int SUM_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TGT = 1'd1;

	localparam logic [CUR_W-1:0] LOW_THRESH_RST = 16'd5;
	localparam logic [CNT_W-1:0] SAMPLE_TGT_RST = 16'd100;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [CUR_W-1:0] max_cur;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] alerts;
	} rec_t;

	// controller -> datapath
	typedef struct packed {
		logic in_ready;
		logic rd_item;
		logic rd_scan;
		logic upd;
		logic scan_start;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_fire;
		logic scan_last;
		logic out_free;
	} stat_t;

endpackage

[hw/rtl/pcst_sample_if.sv]
// Input channel: one current sample tagged with its lamp index.
// Depends on pcst_pkg.
interface pcst_sample_if;
	import pcst_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] lamp_index;
	logic [CUR_W-1:0] current;

	modport source (output valid, output lamp_index, output current, input ready);
	modport sink (input valid, input lamp_index, input current, output ready);
endinterface

[hw/rtl/pcst_result_if.sv]
// Output channel: updated lamp record plus the insufficient flag.
// Depends on pcst_pkg.
interface pcst_result_if;
	import pcst_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] lamp_index_out;
	logic [CUR_W-1:0] max_current;
	logic [CNT_W-1:0] sample_count;
	logic [SUM_W-1:0] current_sum;
	logic [CNT_W-1:0] alert_count;
	logic             insufficient;

	modport source (output valid, output lamp_index_out, output max_current,
		output sample_count, output current_sum, output alert_count,
		output insufficient, input ready);
	modport sink (input valid, input lamp_index_out, input max_current,
		input sample_count, input current_sum, input alert_count,
		input insufficient, output ready);
endinterface

[hw/rtl/pcst_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on pcst_pkg.
interface pcst_cfg_if;
	import pcst_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/pcst_ctrl.sv]
// Sequencer: read-modify-write of one lamp record, then a scan of all records.
// Depends on pcst_pkg; drives pcst_dpath through cmd_t / stat_t.
module pcst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  pcst_pkg::stat_t stat,
	output pcst_pkg::cmd_t  cmd
);
	import pcst_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_fire) state_nxt = ST_RD;
			end
			ST_RD: begin
				cmd.rd_item = 1'b1;
				state_nxt   = ST_MOD;
			end
			ST_MOD: begin
				cmd.upd        = 1'b1;
				cmd.scan_start = 1'b1;
				state_nxt      = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.rd_scan = 1'b1;
				if (stat.scan_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last scanned entry is compared here
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[hw/rtl/pcst_dpath.sv]
// Datapath: record memory with valid bits, update logic, target scan,
// configuration registers and output register. Depends on pcst_pkg.
module pcst_dpath #(
	parameter int NUM_LAMPS = pcst_pkg::NUM_LAMPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	pcst_sample_if.sink     samples,
	pcst_result_if.source   results,
	pcst_cfg_if.sink        cfg,
	input  pcst_pkg::cmd_t  cmd,
	output pcst_pkg::stat_t stat
);
	import pcst_pkg::*;

	localparam int AW = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LAMPS - 1);

	logic [CUR_W-1:0] low_thresh_q;
	logic [CNT_W-1:0] sample_tgt_q;

	logic [IDX_W-1:0] idx_q;
	logic [CUR_W-1:0] cur_q;

	rec_t             mem [NUM_LAMPS];
	logic [NUM_LAMPS-1:0] valid_q;
	rec_t             rd_data_q;
	logic             rd_vld_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    item_addr;
	logic             in_range;

	logic [AW-1:0]    scan_cnt_q;
	logic             chk_q;
	logic             insuf_q;

	rec_t             old_rec;
	rec_t             new_rec;
	rec_t             res_q;

	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	rec_t             out_rec_q;
	logic             out_insuf_q;

	assign samples.ready = cmd.in_ready;
	assign cfg.ready     = 1'b1;

	assign stat.in_fire   = samples.valid & cmd.in_ready;
	assign stat.scan_last = (scan_cnt_q == LAST_ADDR);
	assign stat.out_free  = ~out_valid_q | results.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thresh_q <= LOW_THRESH_RST;
			sample_tgt_q <= SAMPLE_TGT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOW_THRESH: low_thresh_q <= cfg.data;
				REG_SAMPLE_TGT: sample_tgt_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (stat.in_fire) begin
			idx_q <= samples.lamp_index;
			cur_q <= samples.current;
		end
	end

	assign item_addr = AW'(idx_q);
	assign in_range  = ({{(32-IDX_W){1'b0}}, idx_q} < 32'(NUM_LAMPS));
	assign rd_addr   = cmd.rd_item ? item_addr : scan_cnt_q;

	// record memory, one read port, registered read data
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (cmd.upd && in_range) mem[item_addr] <= new_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (cmd.upd && in_range) valid_q[item_addr] <= 1'b1;
		end
	end

	// an entry never written reads as zero
	assign old_rec = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		new_rec = old_rec;
		if (cur_q > old_rec.max_cur) new_rec.max_cur = cur_q;
		if (old_rec.count != CNT_MAX) begin
			new_rec.count = old_rec.count + CNT_W'(1);
			new_rec.sum   = old_rec.sum + SUM_W'(cur_q);
		end
		if (cur_q < low_thresh_q && old_rec.alerts != CNT_MAX)
			new_rec.alerts = old_rec.alerts + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) res_q <= in_range ? new_rec : '0;
	end

	// scan: any lamp below target keeps the flag set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			chk_q      <= 1'b0;
			insuf_q    <= 1'b0;
		end else begin
			chk_q <= cmd.rd_scan;
			if (cmd.scan_start) begin
				scan_cnt_q <= '0;
				insuf_q    <= 1'b0;
			end else begin
				if (cmd.rd_scan) scan_cnt_q <= scan_cnt_q + AW'(1);
				if (chk_q && old_rec.count < sample_tgt_q) insuf_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q   <= idx_q;
			out_rec_q   <= res_q;
			out_insuf_q <= insuf_q;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.lamp_index_out = out_idx_q;
	assign results.max_current    = out_rec_q.max_cur;
	assign results.sample_count   = out_rec_q.count;
	assign results.current_sum    = out_rec_q.sum;
	assign results.alert_count    = out_rec_q.alerts;
	assign results.insufficient   = out_insuf_q;

endmodule

[hw/rtl/per_channel_current_stats_table.sv]
// Channel   Dir  Beat contents
// samples   in   lamp_index, current
// results   out  lamp_index_out, max_current, sample_count, current_sum,
//                alert_count, insufficient
// cfg       in   index, data (0: low current threshold, 1: sample target)
//
// Each sample passes through accept, record read, update/write,
// then one memory read per lamp to check counts against the target.
// Samples are accepted one at a time; the next is taken while a result
// still waits in the output register. Reset clears all records via valid bits.
// A stalled result holds the sequencer only at the hand-over to the output register.
module per_channel_current_stats_table #(
	parameter int NUM_LAMPS = pcst_pkg::NUM_LAMPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pcst_sample_if.sink   samples,
	pcst_result_if.source results,
	pcst_cfg_if.sink      cfg
);
	import pcst_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pcst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	pcst_dpath #(
		.NUM_LAMPS (NUM_LAMPS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

[test/per_channel_current_stats_table_tb.sv]
`timescale 1ns / 1ps
// Testbench for per_channel_current_stats_table: predicts each lamp record and the
// insufficient flag, and checks every result beat in order.
// Depends on pcst_pkg, pcst_sample_if, pcst_result_if and pcst_cfg_if.
module per_channel_current_stats_table_tb;
	import pcst_pkg::*;

	localparam int NUM_LAMPS = NUM_LAMPS_DEF;

	typedef struct packed {
		logic [IDX_W-1:0] lamp;
		logic [CUR_W-1:0] current;
	} sample_t;

	typedef struct packed {
		logic [IDX_W-1:0] lamp;
		logic [CUR_W-1:0] peak;
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] alerts;
		logic             insufficient;
	} lamp_record_t;

	logic clk = 1'b0;
	logic arst_n;

	pcst_sample_if samples();
	pcst_result_if results();
	pcst_cfg_if    cfg();

	per_channel_current_stats_table #(.NUM_LAMPS(NUM_LAMPS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.cfg     (cfg)
	);

	// predicted table and register copies
	logic [CUR_W-1:0] peak_mem  [NUM_LAMPS] = '{default: '0};
	logic [CNT_W-1:0] count_mem [NUM_LAMPS] = '{default: '0};
	logic [SUM_W-1:0] sum_mem   [NUM_LAMPS] = '{default: '0};
	logic [CNT_W-1:0] alert_mem [NUM_LAMPS] = '{default: '0};
	logic [CUR_W-1:0] thresh_reg = LOW_THRESH_RST;
	logic [CNT_W-1:0] target_reg = SAMPLE_TGT_RST;

	sample_t      sample_queue[$];
	lamp_record_t awaited_records[$];
	int           gap;
	int           hold;
	bit           quiet = 1'b0;
	int           fail_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lamp_record_t update_lamp(input logic [IDX_W-1:0] lamp,
			input logic [CUR_W-1:0] cur);
		lamp_record_t rec;
		int           at_target;
		rec = '0;
		rec.lamp = lamp;
		if (lamp < NUM_LAMPS) begin
			if (cur > peak_mem[lamp])
				peak_mem[lamp] = cur;
			// sum freezes together with the count
			if (count_mem[lamp] != CNT_MAX) begin
				count_mem[lamp] = count_mem[lamp] + 1'b1;
				sum_mem[lamp] = sum_mem[lamp] + cur;
			end
			if (cur < thresh_reg && alert_mem[lamp] != CNT_MAX)
				alert_mem[lamp] = alert_mem[lamp] + 1'b1;
			rec.peak = peak_mem[lamp];
			rec.count = count_mem[lamp];
			rec.sum = sum_mem[lamp];
			rec.alerts = alert_mem[lamp];
		end
		at_target = 0;
		for (int k = 0; k < NUM_LAMPS; k++)
			if (count_mem[k] >= target_reg)
				at_target++;
		rec.insufficient = (at_target < NUM_LAMPS);
		return rec;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet)
			return 0;
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [CUR_W-1:0] rand_current();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		if (roll < 5)
			return CUR_W'($urandom_range(0, 15));
		return CUR_W'($urandom_range(0, 65535));
	endfunction

	task automatic queue_sample(input int lamp, input int cur);
		sample_t s;
		s.lamp = IDX_W'(lamp);
		s.current = CUR_W'(cur);
		sample_queue.push_back(s);
	endtask

	// looked at on the falling edge so that the driver's updates have settled
	task automatic wait_drained();
		do @(negedge clk);
		while (sample_queue.size() != 0 || samples.valid || awaited_records.size() != 0);
		@(posedge clk);
	endtask

	task automatic configure(input logic [CUR_W-1:0] thr, input logic [CNT_W-1:0] tgt);
		cfg.valid <= 1'b1;
		cfg.index <= REG_LOW_THRESH;
		cfg.data <= thr;
		do @(posedge clk); while (!cfg.ready);
		thresh_reg = thr;
		cfg.index <= REG_SAMPLE_TGT;
		cfg.data <= tgt;
		do @(posedge clk); while (!cfg.ready);
		target_reg = tgt;
		cfg.valid <= 1'b0;
	endtask

	task automatic random_samples(input int n);
		for (int i = 0; i < n; i++)
			queue_sample($urandom_range(0, NUM_LAMPS - 1), int'(rand_current()));
		wait_drained();
	endtask

	// sample driver
	always @(posedge clk or negedge arst_n) begin : sample_driver
		sample_t nxt;
		if (!arst_n) begin
			samples.valid <= 1'b0;
			samples.lamp_index <= '0;
			samples.current <= '0;
			gap <= 0;
		end else begin
			if (samples.valid && samples.ready)
				awaited_records.push_back(update_lamp(samples.lamp_index, samples.current));
			if (!samples.valid || samples.ready) begin
				if (gap != 0) begin
					samples.valid <= 1'b0;
					gap <= gap - 1;
				end else if (sample_queue.size() != 0) begin
					nxt = sample_queue.pop_front();
					samples.valid <= 1'b1;
					samples.lamp_index <= nxt.lamp;
					samples.current <= nxt.current;
					gap <= pick_gap();
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin : result_monitor
		lamp_record_t got;
		lamp_record_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
			hold <= 0;
		end else begin
			if (results.valid && results.ready) begin
				got = {results.lamp_index_out, results.max_current, results.sample_count,
					results.current_sum, results.alert_count, results.insufficient};
				if (awaited_records.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat, lamp %0d", got.lamp);
				end else begin
					want = awaited_records.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("expected: lamp %0d peak %0d count %0d sum %0d alerts %0d insuff %b",
								want.lamp, want.peak, want.count, want.sum, want.alerts,
								want.insufficient);
							$display("actual:   lamp %0d peak %0d count %0d sum %0d alerts %0d insuff %b",
								got.lamp, got.peak, got.count, got.sum, got.alerts,
								got.insufficient);
						end
					end
				end
			end
			if (hold != 0) begin
				results.ready <= 1'b0;
				hold <= hold - 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				results.ready <= 1'b0;
				hold <= pick_gap();
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int min_count;
		arst_n <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_LOW_THRESH;
		cfg.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values; back-to-back hits on one lamp, threshold edge
		queue_sample(0, 0);
		queue_sample(0, 0);
		queue_sample(0, 16'hFFFF);
		queue_sample(0, 4);
		queue_sample(0, 5);
		queue_sample(15, 16'hFFFF);
		queue_sample(15, 16'hFFFE);
		queue_sample(5, 16'hAAAA);
		queue_sample(10, 16'h5555);
		wait_drained();

		// target of one: flag drops once the last untouched lamp gets a beat
		configure(16'd0, 16'd1);
		for (int k = 0; k < NUM_LAMPS; k++)
			queue_sample(k, 0);
		wait_drained();

		// target of zero: every lamp is sufficient
		configure(16'hFFFF, 16'd0);
		random_samples(90);

		for (int p = 0; p < 5; p++) begin
			min_count = 32'hFFFF;
			for (int k = 0; k < NUM_LAMPS; k++)
				if (int'(count_mem[k]) < min_count)
					min_count = int'(count_mem[k]);
			// target just above the laggard so the flag toggles within the phase; phase 3 takes any nonzero target
			configure(CUR_W'($urandom_range(0, 1) ? $urandom_range(0, 16)
					: $urandom_range(0, 65535)),
				CNT_W'((p == 3) ? $urandom_range(1, 65535)
					: min_count + $urandom_range(1, 6)));
			quiet = (p == 1);
			random_samples(110);
		end

		// full-scale peak on one lamp, then a neighbour, then a zero sample
		configure(16'hFFFF, 16'hFFFF);
		queue_sample(7, 16'hFFFF);
		queue_sample(8, 16'hFFFF);
		queue_sample(7, 0);
		wait_drained();

		repeat (2 * NUM_LAMPS + 10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#(2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[per_channel_current_stats_table.f]
hw/rtl/pcst_pkg.sv
hw/rtl/pcst_sample_if.sv
hw/rtl/pcst_result_if.sv
hw/rtl/pcst_cfg_if.sv
hw/rtl/pcst_ctrl.sv
hw/rtl/pcst_dpath.sv
hw/rtl/per_channel_current_stats_table.sv
test/per_channel_current_stats_table_tb.sv
